[rtl/pip_pkg.sv]
// Shared types and constants for the point-in-polygon test block.
// Used by the vertex memory, the shared multiplier and the top-level sequencer.
// No dependencies.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SUM_W        = PROD_W + 1;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    // Exact difference of two coordinates, one bit wider than a coordinate.
    function automatic diff_t coord_diff(input coord_t a, input coord_t b);
        diff_t wa;
        diff_t wb;
        wa = diff_t'(a);
        wb = diff_t'(b);
        return wa - wb;
    endfunction

endpackage

[rtl/pip_vertex_mem.sv]
// Polygon vertex store: one write port, one read port with registered data.
// Depends on pip_pkg for the depth and the vertex type.
module pip_vertex_mem
    import pip_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [VIDX_W-1:0] wr_addr,
    input  vertex_t           wr_data,
    input  logic [VIDX_W-1:0] rd_addr,
    output vertex_t           rd_data
);

    vertex_t mem [MAX_VERTICES];
    vertex_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/pip_mul_unit.sv]
// Shared signed multiplier with a registered product.
// Depends on pip_pkg for the operand and product types.
module pip_mul_unit
    import pip_pkg::*;
(
    input  logic  aclk,
    input  diff_t op_a,
    input  diff_t op_b,
    output prod_t product
);

    prod_t product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= prod_t'(op_a) * prod_t'(op_b);
    end

    assign product = product_reg;

endmodule

[rtl/point_in_polygon_test.sv]
// Point-in-polygon test by even-odd ray casting. Clear and append words are handled in IDLE,
// which stays ready for the next word. A degenerate or out-of-box query goes straight to DONE;
// otherwise the edges share one multiplier: FETCH and LOAD for the first vertex, then FETCH,
// LOAD, EDGE and ACC per edge, with MUL1 and MUL2 before ACC where the y span holds (the closing
// edge has no FETCH or LOAD). DONE shows the result once the output is free, then goes to IDLE.
// Synchronous active-low reset (aresetn) empties the polygon and clears the box and overflow flag.
module point_in_polygon_test
    import pip_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_req_type,
    input  logic [31:0]  s_coord_x,
    input  logic [31:0]  s_coord_y,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_inside_res,
    output logic         m_degenerate,
    output logic         m_overflowed
);

    // The sequencer fetches one vertex per edge from the store. The first vertex is kept
    // aside so that the closing edge (last back to first) needs no second read. Each edge
    // takes its y-span test in EDGE and, when the span holds, two multiplies on the shared
    // unit followed by one wide add and sign test in ACC.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_EDGE,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Polygon state.
    logic [CNT_W-1:0]  count_reg;
    coord_t            box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    logic              overflow_reg;

    // Query working state.
    coord_t            px_reg, py_reg;
    logic [VIDX_W-1:0] idx_reg;
    logic              first_done_reg;
    logic              closing_reg;
    vertex_t           first_reg, prev_reg, cur_reg;
    diff_t             a1_reg, b1_reg, a2_reg, b2_reg;
    logic              hit_reg, dy_pos_reg;
    prod_t             p1_reg;
    logic              parity_reg;

    // Staged result and output word.
    logic              res_inside_reg, res_degen_reg, res_ovf_reg;
    logic              m_valid_reg, m_inside_reg, m_degen_reg, m_ovf_reg;

    coord_t            in_x, in_y;
    logic              accept, do_append, mem_wr;
    vertex_t           mem_rd, mem_wd;
    diff_t             mul_a, mul_b;
    prod_t             product;
    sum_t              cross_sum;
    logic              cross_hit;
    logic              span_hit;
    logic              in_box;
    logic [CNT_W-1:0]  last_idx;

    assign in_x      = coord_t'(s_coord_x);
    assign in_y      = coord_t'(s_coord_y);
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign do_append = accept && (s_req_type == REQ_APPEND);
    assign mem_wr    = do_append && (count_reg < CNT_W'(MAX_VERTICES));
    assign mem_wd    = '{x: in_x, y: in_y};
    assign last_idx  = count_reg - CNT_W'(1);

    assign in_box = (box_min_x_reg <= in_x) && (in_x <= box_max_x_reg) &&
                    (box_min_y_reg <= in_y) && (in_y <= box_max_y_reg);

    // Half-open y span: the lower end is excluded, the upper end included.
    always_comb begin
        if (prev_reg.y < cur_reg.y) begin
            span_hit = (prev_reg.y < py_reg) && (py_reg <= cur_reg.y);
        end else begin
            span_hit = (cur_reg.y < py_reg) && (py_reg <= prev_reg.y);
        end
    end

    // The first multiply takes (x1 - px) * dy, the second (x2 - x1) * (py - y1).
    assign mul_a = (state_reg == ST_MUL2) ? a2_reg : a1_reg;
    assign mul_b = (state_reg == ST_MUL2) ? b2_reg : b1_reg;

    // Their sum is (crossing x - px) * dy; the crossing lies strictly right of the point
    // when that product has the sign of dy and is not zero.
    assign cross_sum = sum_t'(p1_reg) + sum_t'(product);
    always_comb begin
        if (dy_pos_reg) begin
            cross_hit = !cross_sum[SUM_W-1] && (cross_sum != '0);
        end else begin
            cross_hit = cross_sum[SUM_W-1];
        end
    end

    pip_vertex_mem u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (count_reg[VIDX_W-1:0]),
        .wr_data (mem_wd),
        .rd_addr (idx_reg),
        .rd_data (mem_rd)
    );

    pip_mul_unit u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            box_min_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
            overflow_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // In DONE the output handshake is handled together with the new word.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (s_req_type)
                            REQ_CLEAR: begin
                                count_reg     <= '0;
                                box_min_x_reg <= '0;
                                box_min_y_reg <= '0;
                                box_max_x_reg <= '0;
                                box_max_y_reg <= '0;
                                overflow_reg  <= 1'b0;
                            end
                            REQ_APPEND: begin
                                if (!mem_wr) begin
                                    overflow_reg <= 1'b1;
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                    if (count_reg == '0) begin
                                        box_min_x_reg <= in_x;
                                        box_max_x_reg <= in_x;
                                        box_min_y_reg <= in_y;
                                        box_max_y_reg <= in_y;
                                    end else begin
                                        if (in_x < box_min_x_reg) box_min_x_reg <= in_x;
                                        if (in_x > box_max_x_reg) box_max_x_reg <= in_x;
                                        if (in_y < box_min_y_reg) box_min_y_reg <= in_y;
                                        if (in_y > box_max_y_reg) box_max_y_reg <= in_y;
                                    end
                                end
                            end
                            REQ_QUERY: begin
                                px_reg         <= in_x;
                                py_reg         <= in_y;
                                res_ovf_reg    <= overflow_reg;
                                res_degen_reg  <= (count_reg <= CNT_W'(2));
                                res_inside_reg <= 1'b0;
                                parity_reg     <= 1'b0;
                                idx_reg        <= '0;
                                first_done_reg <= 1'b0;
                                closing_reg    <= 1'b0;
                                if ((count_reg <= CNT_W'(2)) || !in_box) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    state_reg <= ST_FETCH;
                                end
                            end
                            default: begin
                                // The unused request code is taken and ignored.
                            end
                        endcase
                    end
                end

                ST_FETCH: begin
                    state_reg <= ST_LOAD;
                end

                ST_LOAD: begin
                    cur_reg <= mem_rd;
                    if (!first_done_reg) begin
                        first_reg      <= mem_rd;
                        prev_reg       <= mem_rd;
                        first_done_reg <= 1'b1;
                        idx_reg        <= VIDX_W'(1);
                        state_reg      <= ST_FETCH;
                    end else begin
                        state_reg <= ST_EDGE;
                    end
                end

                ST_EDGE: begin
                    hit_reg    <= span_hit;
                    a1_reg     <= coord_diff(prev_reg.x, px_reg);
                    b1_reg     <= coord_diff(cur_reg.y, prev_reg.y);
                    a2_reg     <= coord_diff(cur_reg.x, prev_reg.x);
                    b2_reg     <= coord_diff(py_reg, prev_reg.y);
                    dy_pos_reg <= (prev_reg.y < cur_reg.y);
                    state_reg  <= span_hit ? ST_MUL1 : ST_ACC;
                end

                ST_MUL1: begin
                    state_reg <= ST_MUL2;
                end

                ST_MUL2: begin
                    p1_reg    <= product;
                    state_reg <= ST_ACC;
                end

                ST_ACC: begin
                    parity_reg <= parity_reg ^ (hit_reg && cross_hit);
                    prev_reg   <= cur_reg;
                    if (closing_reg) begin
                        res_inside_reg <= parity_reg ^ (hit_reg && cross_hit);
                        state_reg      <= ST_DONE;
                    end else if ({1'b0, idx_reg} == last_idx) begin
                        cur_reg     <= first_reg;
                        closing_reg <= 1'b1;
                        state_reg   <= ST_EDGE;
                    end else begin
                        idx_reg   <= idx_reg + VIDX_W'(1);
                        state_reg <= ST_FETCH;
                    end
                end

                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_inside_reg <= res_inside_reg;
                        m_degen_reg  <= res_degen_reg;
                        m_ovf_reg    <= res_ovf_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;
    assign m_degenerate = m_degen_reg;
    assign m_overflowed = m_ovf_reg;

endmodule

[test/point_in_polygon_test_tb.sv]
// Self-checking testbench for the point_in_polygon_test block: polygon words and queries.
// Depends on pip_pkg (rtl/pip_pkg.sv) and the point_in_polygon_test RTL; reads no files.
// Holds its own ray-casting predictor in a small scoreboard class.
module point_in_polygon_test_tb;
    import pip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The one request code that the block is meant to ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Total input words to send, not counting ignored ones.
    localparam int WORD_TARGET = 600;
    // A query on a full store walks every edge, and a result may then wait on a stalled
    // receiver; the limit on cycles without any handshake leaves room for both.
    localparam int IDLE_LIMIT = 4000;
    // Settle time after the last result, about one full-store query.
    localparam int DRAIN_CYCLES = 400;

    // One expected answer to a query.
    typedef struct packed {
        logic in_poly;
        logic degen;
        logic ovf;
    } verdict_t;

    // The scoreboard keeps its own copy of the polygon and predicts every query.
    class pip_scoreboard;
        coord_t      vert_x[MAX_VERTICES];
        coord_t      vert_y[MAX_VERTICES];
        int unsigned vert_count;
        coord_t      min_x, min_y, max_x, max_y;
        logic        ovf_flag;
        verdict_t    verdicts[$];
        int          errors;

        function new();
            vert_count = 0;
            min_x = '0;
            min_y = '0;
            max_x = '0;
            max_y = '0;
            ovf_flag = 1'b0;
            errors = 0;
        endfunction

        // True if the edge (x1,y1)-(x2,y2) crosses the ray from (px,py) towards +x.
        // The crossing x is compared with px by cross-multiplication, so no division.
        function bit ray_crosses(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                                 coord_t px, coord_t py);
            logic signed [127:0] wx1, wy1, wx2, wy2, wpx, wpy, dy, s;
            coord_t lo_y, hi_y;
            lo_y = (y1 < y2) ? y1 : y2;
            hi_y = (y1 < y2) ? y2 : y1;
            if (!(lo_y < py && py <= hi_y))
                return 1'b0;
            wx1 = 128'(x1);
            wy1 = 128'(y1);
            wx2 = 128'(x2);
            wy2 = 128'(y2);
            wpx = 128'(px);
            wpy = 128'(py);
            dy = wy2 - wy1;
            s = (wx1 - wpx) * dy + (wx2 - wx1) * (wpy - wy1);
            if (dy > 0)
                return s > 0;
            return s < 0;
        endfunction

        // Called for every word the block accepts.
        function void note_word(logic [1:0] req, coord_t px, coord_t py);
            verdict_t v;
            int unsigned j;
            bit odd;
            case (req)
                REQ_CLEAR: begin
                    vert_count = 0;
                    min_x = '0;
                    min_y = '0;
                    max_x = '0;
                    max_y = '0;
                    ovf_flag = 1'b0;
                end
                REQ_APPEND: begin
                    if (vert_count >= MAX_VERTICES) begin
                        ovf_flag = 1'b1;
                    end else begin
                        vert_x[vert_count] = px;
                        vert_y[vert_count] = py;
                        if (vert_count == 0) begin
                            min_x = px;
                            max_x = px;
                            min_y = py;
                            max_y = py;
                        end else begin
                            if (px < min_x) min_x = px;
                            if (px > max_x) max_x = px;
                            if (py < min_y) min_y = py;
                            if (py > max_y) max_y = py;
                        end
                        vert_count++;
                    end
                end
                REQ_QUERY: begin
                    v.degen = (vert_count <= 2);
                    v.ovf = ovf_flag;
                    odd = 1'b0;
                    if (!v.degen && min_x <= px && px <= max_x &&
                        min_y <= py && py <= max_y) begin
                        for (int unsigned i = 0; i < vert_count; i++) begin
                            j = (i + 1 >= vert_count) ? 0 : i + 1;
                            if (ray_crosses(vert_x[i], vert_y[i], vert_x[j], vert_y[j],
                                            px, py))
                                odd = ~odd;
                        end
                    end
                    v.in_poly = odd;
                    verdicts = {verdicts, v};
                end
                default: ;
            endcase
        endfunction

        // Called for every result the testbench accepts.
        function void check_result(logic ins, logic deg, logic ovf);
            verdict_t v;
            if (verdicts.size() == 0) begin
                $error("result word with no query waiting: inside=%0b degenerate=%0b overflowed=%0b",
                       ins, deg, ovf);
                errors++;
                return;
            end
            v = verdicts.pop_front();
            if (ins !== v.in_poly) begin
                $error("inside_res: expected %0b, actual %0b", v.in_poly, ins);
                errors++;
            end
            if (deg !== v.degen) begin
                $error("degenerate: expected %0b, actual %0b", v.degen, deg);
                errors++;
            end
            if (ovf !== v.ovf) begin
                $error("overflowed: expected %0b, actual %0b", v.ovf, ovf);
                errors++;
            end
        endfunction

        function int pending_count();
            return verdicts.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_CLEAR;
    logic [31:0] s_coord_x = '0;
    logic [31:0] s_coord_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_inside_res;
    logic        m_degenerate;
    logic        m_overflowed;

    pip_scoreboard sb;

    int words_sent = 0;   // words handed to the block, ignored ones excluded
    int burst_left = 0;   // words left in the sender's current burst
    int idle_cycles = 0;  // cycles since the last handshake on either channel
    int ready_cycle = 0;
    int ready_mode = 0;

    point_in_polygon_test DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_coord_x    (s_coord_x),
        .s_coord_y    (s_coord_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res),
        .m_degenerate (m_degenerate),
        .m_overflowed (m_overflowed)
    );

    always #5 aclk = ~aclk;

    // Both channels are observed right after the rising edge, where the values seen are
    // still the ones from before the edge, so the order of events in the step does not
    // matter. A query's result comes out only after its query word was accepted, so noting
    // and checking in the same step never interfere.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_word(s_req_type, s_coord_x, s_coord_y);
            if (m_valid && m_ready)
                sb.check_result(m_inside_res, m_degenerate, m_overflowed);
        end
    end

    // Watchdog: the run is dead if neither channel moves a word for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("point_in_polygon_test regression: fail");
            $finish;
        end
    end

    // The receiver stalls on a pattern of its own, drawn anew at random from four modes:
    // always ready, coin flip, mostly stalled, or a fixed duty cycle.
    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 256 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((ready_cycle % 7) < 3);
        endcase
    end

    // Sends one word and returns in the step of the edge that accepted it. The sender works
    // in bursts; between bursts it drops valid for a random gap, and sometimes for none.
    task automatic send_word(input logic [1:0] req, input coord_t cx, input coord_t cy);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_coord_x  <= cx;
        s_coord_y  <= cy;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        burst_left--;
        if (req != REQ_UNUSED)
            words_sent++;
    endtask

    // A coordinate drawn from one of four scales: a tiny grid where equal y values and
    // horizontal edges are common, a mid range, the full range, or near the extremes.
    function automatic coord_t pick_coord(int scale);
        case (scale)
            0: return $urandom_range(0, 16) - 8;
            1: return $urandom_range(0, 200000) - 100000;
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    4: return 32'h8000_0000 + $urandom_range(0, 3);
                    default: return 32'h7fff_ffff - $urandom_range(0, 3);
                endcase
            end
        endcase
    endfunction

    // Uniform pick from the inclusive range lo..hi.
    function automatic coord_t pick_between(longint lo, longint hi);
        longint unsigned r;
        longint unsigned span;
        r = {$urandom, $urandom};
        span = hi - lo + 1;
        return coord_t'(lo + longint'(r % span));
    endfunction

    // A well-formed sequence: clear, a polygon of random size, then a few queries aimed
    // mostly inside the box, at vertices and on the box boundary. A few polygons fill the
    // store and run past it, which raises the overflow flag.
    task automatic run_polygon();
        coord_t kept_x[MAX_VERTICES];
        coord_t kept_y[MAX_VERTICES];
        coord_t cx, cy, qx, qy;
        longint lo_x, hi_x, lo_y, hi_y;
        int n, kept, scale, nq, pick, k;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            n = $urandom_range(3, 10);
        else if (pick < 93)
            n = $urandom_range(11, 40);
        else if (pick < 97)
            n = $urandom_range(60, MAX_VERTICES);
        else
            n = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 6);
        pick = $urandom_range(0, 99);
        scale = (pick < 30) ? 0 : (pick < 60) ? 1 : (pick < 85) ? 2 : 3;
        send_word(REQ_CLEAR, $urandom, $urandom);
        kept = 0;
        lo_x = 0;
        hi_x = 0;
        lo_y = 0;
        hi_y = 0;
        for (int i = 0; i < n; i++) begin
            cx = pick_coord(scale);
            cy = pick_coord(scale);
            send_word(REQ_APPEND, cx, cy);
            if (kept < MAX_VERTICES) begin
                kept_x[kept] = cx;
                kept_y[kept] = cy;
                if (kept == 0 || cx < lo_x) lo_x = cx;
                if (kept == 0 || cx > hi_x) hi_x = cx;
                if (kept == 0 || cy < lo_y) lo_y = cy;
                if (kept == 0 || cy > hi_y) hi_y = cy;
                kept++;
            end
        end
        nq = $urandom_range(1, 6);
        for (int q = 0; q < nq; q++) begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, kept - 1);
            if (pick < 45) begin
                qx = pick_between(lo_x, hi_x);
                qy = pick_between(lo_y, hi_y);
            end else if (pick < 55) begin
                // Exactly on a vertex.
                qx = kept_x[k];
                qy = kept_y[k];
            end else if (pick < 68) begin
                // On the level of a vertex, where the half-open y test decides.
                qx = pick_between(lo_x, hi_x);
                qy = kept_y[k];
            end else if (pick < 82) begin
                // On the box boundary.
                qx = $urandom_range(0, 1) ? coord_t'(lo_x) : coord_t'(hi_x);
                qy = $urandom_range(0, 1) ? coord_t'(lo_y) : pick_between(lo_y, hi_y);
                if ($urandom_range(0, 1)) begin
                    cx = qx;
                    qx = pick_between(lo_x, hi_x);
                    qy = $urandom_range(0, 1) ? coord_t'(lo_y) : coord_t'(hi_y);
                end
            end else begin
                qx = pick_coord(scale);
                qy = pick_coord(scale);
            end
            send_word(REQ_QUERY, qx, qy);
        end
    endtask

    initial begin
        int pick, k;
        logic [1:0] req;
        sb = new();

        // Reset is held low once, at the start.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. A query on the empty store, then the ignored request code with
        // all coordinate bits set and all clear.
        send_word(REQ_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send_word(REQ_QUERY, 32'h7fff_ffff, 32'h8000_0000);
        send_word(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        send_word(REQ_UNUSED, 32'h0000_0000, 32'h0000_0000);

        // A triangle spanning the whole coordinate range: two vertices are still
        // degenerate, the third makes a real polygon. Then the origin, two box corners and the apex.
        send_word(REQ_APPEND, 32'h8000_0000, 32'h8000_0000);
        send_word(REQ_APPEND, 32'h7fff_ffff, 32'h8000_0000);
        send_word(REQ_QUERY, 32'h0000_0000, 32'h0000_0000);
        send_word(REQ_APPEND, 32'h0000_0000, 32'h7fff_ffff);
        send_word(REQ_QUERY, 32'h0000_0000, 32'h0000_0000);
        send_word(REQ_QUERY, 32'h8000_0000, 32'h8000_0000);
        send_word(REQ_QUERY, 32'h0000_0000, 32'h7fff_ffff);
        send_word(REQ_QUERY, 32'h7fff_ffff, 32'h7fff_ffff);

        // A square with two horizontal edges: points inside, on the top edge, just
        // outside the box, on the right edge and on a corner.
        send_word(REQ_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        send_word(REQ_APPEND, -32'sd100, -32'sd100);
        send_word(REQ_APPEND,  32'sd100, -32'sd100);
        send_word(REQ_APPEND,  32'sd100,  32'sd100);
        send_word(REQ_APPEND, -32'sd100,  32'sd100);
        send_word(REQ_QUERY,    32'sd0,    32'sd0);
        send_word(REQ_QUERY,    32'sd0,  32'sd100);
        send_word(REQ_QUERY,  32'sd101,    32'sd0);
        send_word(REQ_QUERY,  32'sd100,    32'sd0);
        send_word(REQ_QUERY, -32'sd100, -32'sd100);

        // Random part: mostly well-formed polygons, the rest noise words on whatever
        // polygon is stored, and short runs of at most two appends and some queries, sometimes after a clear.
        while (words_sent < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                run_polygon();
            end else if (pick < 85) begin
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++) begin
                    req = 2'($urandom_range(0, 3));
                    send_word(req, pick_coord($urandom_range(0, 3)),
                              pick_coord($urandom_range(0, 3)));
                end
            end else begin
                if ($urandom_range(0, 1))
                    send_word(REQ_CLEAR, $urandom, $urandom);
                k = $urandom_range(0, 2);
                for (int i = 0; i < k; i++)
                    send_word(REQ_APPEND, pick_coord(0), pick_coord(0));
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    send_word(REQ_QUERY, pick_coord(0), pick_coord(0));
            end
        end
        s_valid <= 1'b0;

        // Drain: every query must be answered, then nothing more may come out.
        while (sb.pending_count() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0)
            $display("point_in_polygon_test regression: pass");
        else
            $display("point_in_polygon_test regression: fail");
        $finish;
    end

endmodule
